// ===== rtl/cdvr_pkg.sv =====
package cdvr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 24;
  localparam int TABLE_LEN    = 24;

  localparam int VEC_W      = 20;
  localparam int POS_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int DB_W       = 8;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int ACC_W      = 32;
  localparam int GUARD_BITS = 8;
  localparam int PROD_W     = 64;
  localparam int RND_SHIFT  = 38;
  localparam int RES_W      = PROD_W - RND_SHIFT;

  localparam int CNT_W     = $clog2(CORDIC_STEPS);
  localparam int TBL_IDX_W = $clog2(TABLE_LEN);
  localparam int NUM_COMP  = 4;
  localparam int COMP_W    = $clog2(NUM_COMP);

  localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(1669);
  localparam logic [DB_W-1:0]   DEADBAND_RESET = DB_W'(1);

  // 1/K of the CORDIC in Q30
  localparam logic signed [ACC_W-1:0] INV_GAIN_Q30 = 32'sd652032875;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 1'd1;

  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // vector component slots
  localparam logic [COMP_W-1:0] COMP_DIR_X   = 2'd0;
  localparam logic [COMP_W-1:0] COMP_DIR_Y   = 2'd1;
  localparam logic [COMP_W-1:0] COMP_PLANE_X = 2'd2;
  localparam logic [COMP_W-1:0] COMP_PLANE_Y = 2'd3;

  // atan(2^-i) in 2^-32 turn, truncated
  localparam logic [ACC_W-1:0] ATAN_TBL [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic                    op;
    logic signed [POS_W-1:0] cursor_x;
    logic signed [VEC_W-1:0] load_dir_x;
    logic signed [VEC_W-1:0] load_dir_y;
    logic signed [VEC_W-1:0] load_plane_x;
    logic signed [VEC_W-1:0] load_plane_y;
  } in_item_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] view_dir_x;
    logic signed [VEC_W-1:0] view_dir_y;
    logic signed [VEC_W-1:0] view_plane_x;
    logic signed [VEC_W-1:0] view_plane_y;
    logic                    rotated;
  } out_item_t;

  typedef struct packed {
    logic              latch;
    logic              setup;
    logic              prep;
    logic              iter;
    logic [CNT_W-1:0]  step;
    logic              mul;
    logic [COMP_W-1:0] mul_idx;
    logic              fin;
    logic [COMP_W-1:0] fin_idx;
    logic              emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_rot;
  } dp_stat_t;

endpackage

// ===== rtl/cdvr_dp.sv =====
module cdvr_dp
  import cdvr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic [GAIN_W-1:0] gain,
  input  logic [DB_W-1:0]   deadband,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  output out_item_t         out_data
);

  in_item_t                item_r;
  logic signed [POS_W-1:0] prev_x_r;
  logic                    have_prev_r;
  logic                    rot_r;
  logic signed [VEC_W-1:0] vec_r [NUM_COMP];
  logic [ANGLE_BITS-1:0]   angle_r;
  logic signed [ACC_W-1:0] acc_r [NUM_COMP];
  logic signed [ACC_W-1:0] z_r;
  logic signed [PROD_W-1:0] prod_r;
  out_item_t               out_r;

  logic signed [POS_W:0]     delta;
  logic [POS_W:0]            mag;
  logic signed [POS_W+GAIN_W+1:0] angle_prod;
  logic signed [ACC_W-1:0]   z_init;
  logic                      flip;
  logic signed [ACC_W-1:0]   acc_nxt [NUM_COMP];
  logic signed [ACC_W-1:0]   z_nxt;
  logic signed [ACC_W-1:0]   atan_val;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [RES_W-1:0]   res;
  logic signed [VEC_W-1:0]   sat;

  // move decision and angle
  always_comb begin
    delta      = {item_r.cursor_x[POS_W-1], item_r.cursor_x} - {prev_x_r[POS_W-1], prev_x_r};
    mag        = delta[POS_W] ? (POS_W+1)'(-delta) : delta;
    angle_prod = (POS_W+GAIN_W+2)'(delta) * (POS_W+GAIN_W+2)'($signed({1'b0, gain}));
    stat.need_rot = (item_r.op == OP_MOVE) && have_prev_r &&
                    (mag > {{(POS_W+1-DB_W){1'b0}}, deadband});
  end

  // quadrant fold, CORDIC step
  always_comb begin
    z_init   = ACC_W'(angle_r) <<< (ACC_W - ANGLE_BITS);
    flip     = (z_init > 32'sh40000000) || (z_init < -32'sh40000000);
    atan_val = ATAN_TBL[TBL_IDX_W'(cmd.step)];
    z_nxt    = z_r;
    for (int k = 0; k < NUM_COMP; k++) begin
      acc_nxt[k] = acc_r[k];
    end
    if (cmd.prep) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        acc_nxt[k] = ACC_W'(vec_r[k]) <<< GUARD_BITS;
        if (flip) begin
          acc_nxt[k] = -acc_nxt[k];
        end
      end
      z_nxt = flip ? (z_init + 32'sh80000000) : z_init;
    end else if (cmd.iter) begin
      for (int l = 0; l < NUM_COMP / 2; l++) begin
        if (!z_r[ACC_W-1]) begin
          acc_nxt[2*l]   = acc_r[2*l]   - (acc_r[2*l+1] >>> cmd.step);
          acc_nxt[2*l+1] = acc_r[2*l+1] + (acc_r[2*l]   >>> cmd.step);
        end else begin
          acc_nxt[2*l]   = acc_r[2*l]   + (acc_r[2*l+1] >>> cmd.step);
          acc_nxt[2*l+1] = acc_r[2*l+1] - (acc_r[2*l]   >>> cmd.step);
        end
      end
      z_nxt = z_r[ACC_W-1] ? (z_r + atan_val) : (z_r - atan_val);
    end
  end

  // gain correction, round half up, saturate
  always_comb begin
    prod_nxt = PROD_W'(acc_r[cmd.mul_idx]) * PROD_W'(INV_GAIN_Q30);
    rnd      = prod_r + (PROD_W'(1) <<< (RND_SHIFT - 1));
    res      = rnd[PROD_W-1:RND_SHIFT];
    if (res > RES_W'(524287)) begin
      sat = 20'sh7FFFF;
    end else if (res < -RES_W'(524288)) begin
      sat = 20'sh80000;
    end else begin
      sat = res[VEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      have_prev_r <= 1'b0;
      rot_r       <= 1'b0;
      for (int k = 0; k < NUM_COMP; k++) begin
        vec_r[k] <= '0;
      end
    end else begin
      if (cmd.setup) begin
        if (item_r.op == OP_LOAD) begin
          vec_r[COMP_DIR_X]   <= item_r.load_dir_x;
          vec_r[COMP_DIR_Y]   <= item_r.load_dir_y;
          vec_r[COMP_PLANE_X] <= item_r.load_plane_x;
          vec_r[COMP_PLANE_Y] <= item_r.load_plane_y;
          rot_r               <= 1'b0;
        end else begin
          rot_r       <= stat.need_rot;
          have_prev_r <= 1'b1;
          prev_x_r    <= item_r.cursor_x;
        end
      end
      if (cmd.fin) begin
        vec_r[cmd.fin_idx] <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.setup) begin
      angle_r <= angle_prod[ANGLE_BITS-1:0];
    end
    for (int k = 0; k < NUM_COMP; k++) begin
      acc_r[k] <= acc_nxt[k];
    end
    z_r <= z_nxt;
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.emit) begin
      out_r <= '{view_dir_x:   vec_r[COMP_DIR_X],
                 view_dir_y:   vec_r[COMP_DIR_Y],
                 view_plane_x: vec_r[COMP_PLANE_X],
                 view_plane_y: vec_r[COMP_PLANE_Y],
                 rotated:      rot_r};
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/cdvr_ctrl.sv =====
module cdvr_ctrl
  import cdvr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.step      = cnt_r;
    cmd.mul_idx   = comp_r;
    cmd.fin_idx   = comp_r - COMP_W'(1);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.need_rot ? S_PREP : S_EMIT;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          comp_nxt  = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_MUL: begin
        // multiply one component, retire the one before it
        cmd.mul = 1'b1;
        cmd.fin = (comp_r != '0);
        if (comp_r == COMP_W'(NUM_COMP - 1)) begin
          state_nxt = S_FIN;
        end else begin
          comp_nxt = comp_r + COMP_W'(1);
        end
      end
      S_FIN: begin
        cmd.fin     = 1'b1;
        cmd.fin_idx = COMP_W'(NUM_COMP - 1);
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/cursor_driven_view_rotation.sv =====
// A rotating move passes through setup, fold, one CORDIC step per cycle, four
// multiplies on the shared gain multiplier, and emit before its result shows.
// A new request is taken only once the last one is emitted; a load, a first move
// or a move inside the deadband skips the fold, CORDIC and multiply steps.
// Reset (rst_n, synchronous, active low): vectors, previous position and its
// flag clear, gain returns to 1669 and deadband to 1.
module cursor_driven_view_rotation
  import cdvr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [GAIN_W-1:0] gain_r;
  logic [DB_W-1:0]   deadband_r;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;

  // Configuration registers; the user must write them only while the block is idle
  // (the block itself does not enforce this), so the datapath reads them directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= GAIN_RESET;
      deadband_r <= DEADBAND_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GAIN) begin
        gain_r <= cfg_wdata[GAIN_W-1:0];
      end else if (cfg_index == CFG_DEADBAND) begin
        deadband_r <= cfg_wdata[DB_W-1:0];
      end
    end
  end

  // Sequencer: hold one request at a time, step the CORDIC, drive the result slot.
  cdvr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: view state, two CORDIC lanes sharing one angle, one gain multiplier,
  // and the result register that lets a finished result wait downstream.
  cdvr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .gain     (gain_r),
    .deadband (deadband_r),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
